// ===== rtl/ihq_pkg.sv =====
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and constants for the indexed max-heap priority queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 8;
  localparam int CNT_BITS     = $clog2(CAPACITY_DEF + 1);

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [31:0]      priority_req;
    logic [KEY_BITS_DEF-1:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [KEY_BITS_DEF-1:0] out_key;
    logic [CNT_BITS-1:0]     occupancy;
  } rsp_t;

endpackage

// ===== rtl/indexed_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Indexed binary max-heap with push, pop-best and remove-by-key commands.
// ----------------------------------------------------------------------------
// One command is taken at a time: start is sampled while busy is low, and
// exactly one result word appears later for one cycle with done high. The
// heap lives in one RAM (priority and key per slot) and the key-to-slot map
// in a second RAM, both with registered read data; present is a flag array
// cleared by reset. A heap level going up takes a parent read, a compare
// and two swap writes; going down it takes two child reads, a compare and
// two swap writes. A rejected command or the no-op code goes straight to
// the result state. There is no clearing pass after reset. The receiver
// cannot stall: results are never held.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ihq_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output ihq_pkg::rsp_t rsp
);

  localparam int CAPACITY = ihq_pkg::CAPACITY_DEF;
  localparam int KEY_BITS = ihq_pkg::KEY_BITS_DEF;
  localparam int SB = $clog2(CAPACITY);
  localparam int CB = ihq_pkg::CNT_BITS;
  localparam int KS = 1 << KEY_BITS;
  localparam int HW = 32 + KEY_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MAPRD = 11'b00000000010,
    S_LASTRD= 11'b00000000100,
    S_TOPWR = 11'b00000001000,
    S_UPRD  = 11'b00000010000,
    S_UPCMP = 11'b00000100000,
    S_DNL   = 11'b00001000000,
    S_DNR   = 11'b00010000000,
    S_DNCMP = 11'b00100000000,
    S_SWAP  = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t state;
  logic [CB-1:0] count;
  logic [KS-1:0] present;
  logic [SB-1:0] cur;        // slot of the moving entry
  logic [HW-1:0] mov;        // moving entry {sign-flipped prio, key}
  logic [HW-1:0] lch;        // left child held during sift-down
  logic [SB-1:0] oth;        // slot being swapped with
  logic [HW-1:0] othv;
  logic          mode_up;    // current sift direction
  logic          then_down;  // remove: try sift-down after sift-up stalls
  logic          moved;      // remove: sift-up moved the entry
  logic          swap_phase;
  logic [2:0]    st;
  logic [KEY_BITS-1:0] okey;

  // heap RAM
  logic          h_we;
  logic [SB-1:0] h_addr;
  logic [HW-1:0] h_wd, h_rd;
  // map RAM
  logic                m_we;
  logic [KEY_BITS-1:0] m_addr;
  logic [SB-1:0]       m_wd, m_rd;

  ihq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd)
  );
  ihq_ram #(.WIDTH(SB), .DEPTH(KS)) u_map (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  function automatic logic beats(input logic [HW-1:0] a, input logic [HW-1:0] b);
    if (a[HW-1:KEY_BITS] != b[HW-1:KEY_BITS]) begin
      return a[HW-1:KEY_BITS] > b[HW-1:KEY_BITS];
    end
    return a[KEY_BITS-1:0] < b[KEY_BITS-1:0];
  endfunction

  logic [KEY_BITS-1:0] ikey;
  logic [HW-1:0]       ient;
  logic [CB:0]         lidx, ridx;
  logic [SB-1:0]       par;

  assign ikey = req.key[KEY_BITS-1:0];
  assign ient = {~req.priority_req[31], req.priority_req[30:0], ikey};
  assign lidx = {cur, 1'b1};
  assign ridx = lidx + 1'b1;
  assign par  = SB'((cur - 1'b1) >> 1);
  assign busy = (state != S_IDLE);

  // memory port control
  always_comb begin
    h_we = 1'b0; h_addr = cur; h_wd = mov;
    m_we = 1'b0; m_addr = mov[KEY_BITS-1:0]; m_wd = cur;
    unique case (state)
      S_IDLE: begin
        m_addr = ikey;
        if (start && req.command == ihq_pkg::CMD_PUSH && !present[ikey]
            && count < CB'(CAPACITY)) begin
          h_we = 1'b1; h_addr = SB'(count); h_wd = ient;
          m_we = 1'b1; m_wd = SB'(count);
        end else if (start && req.command == ihq_pkg::CMD_POP && count != '0) begin
          h_addr = SB'(count - 1'b1);
        end
      end
      S_MAPRD: h_addr = SB'(count);
      S_LASTRD: begin
        h_addr = cur;
      end
      S_TOPWR: begin
        h_we = 1'b1; h_addr = cur; h_wd = mov;
        m_we = 1'b1; m_addr = mov[KEY_BITS-1:0]; m_wd = cur;
      end
      S_UPRD:  h_addr = par;
      S_DNL:   h_addr = SB'(lidx);
      S_DNR:   h_addr = SB'(ridx);
      S_SWAP: begin
        h_we = 1'b1;
        if (!swap_phase) begin
          h_addr = cur; h_wd = othv;
          m_we = 1'b1; m_addr = othv[KEY_BITS-1:0]; m_wd = cur;
        end else begin
          h_addr = oth; h_wd = mov;
          m_we = 1'b1; m_addr = mov[KEY_BITS-1:0]; m_wd = oth;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      present <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_RESP);
      unique case (state)
        S_IDLE: if (start) begin
          okey <= '0; moved <= 1'b0; swap_phase <= 1'b0;
          unique case (req.command)
            ihq_pkg::CMD_PUSH: begin
              mode_up <= 1'b1; then_down <= 1'b0;
              if (present[ikey]) begin
                st <= ihq_pkg::ST_PRESENT; state <= S_RESP;
              end else if (count >= CB'(CAPACITY)) begin
                st <= ihq_pkg::ST_FULL; state <= S_RESP;
              end else begin
                st <= ihq_pkg::ST_DONE;
                present[ikey] <= 1'b1;
                cur <= SB'(count); mov <= ient;
                count <= count + 1'b1;
                state <= S_UPRD;
              end
            end
            ihq_pkg::CMD_POP: begin
              mode_up <= 1'b0; then_down <= 1'b0; cur <= '0;
              if (count == '0) begin
                st <= ihq_pkg::ST_EMPTY; state <= S_RESP;
              end else begin
                st <= ihq_pkg::ST_DONE;
                count <= count - 1'b1;
                state <= S_LASTRD;
              end
            end
            ihq_pkg::CMD_REMOVE: begin
              mode_up <= 1'b1; then_down <= 1'b1;
              if (!present[ikey]) begin
                st <= ihq_pkg::ST_ABSENT; state <= S_RESP;
              end else begin
                st <= ihq_pkg::ST_DONE;
                present[ikey] <= 1'b0;
                count <= count - 1'b1;
                state <= S_MAPRD;
              end
            end
            default: begin
              mode_up <= 1'b1; then_down <= 1'b0;
              st <= ihq_pkg::ST_DONE; state <= S_RESP;
            end
          endcase
        end
        S_MAPRD: begin
          // map read returns the slot; heap port reads last entry
          cur <= m_rd;
          state <= S_LASTRD;
        end
        S_LASTRD: begin
          // h_rd holds the last entry; capture it, top slot read for pop
          mov <= h_rd;
          if (mode_up && cur >= SB'(count)) state <= S_RESP; // removed the last slot
          else state <= S_TOPWR;
        end
        S_TOPWR: begin
          if (!mode_up) begin
            okey <= h_rd[KEY_BITS-1:0];
            present[h_rd[KEY_BITS-1:0]] <= 1'b0;
            if (count == '0) state <= S_RESP;
            else state <= S_DNL;
          end else begin
            state <= S_UPRD;
          end
        end
        S_UPRD: begin
          if (cur == '0) begin
            if (then_down && !moved) begin
              mode_up <= 1'b0; state <= S_DNL;
            end else state <= S_RESP;
          end else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (beats(mov, h_rd)) begin
            oth <= par; othv <= h_rd; moved <= 1'b1;
            state <= S_SWAP;
          end else if (then_down && !moved) begin
            mode_up <= 1'b0; state <= S_DNL;
          end else state <= S_RESP;
        end
        S_DNL: begin
          if (lidx >= (CB+1)'(count)) state <= S_RESP;
          else state <= S_DNR;
        end
        S_DNR: begin
          lch <= h_rd;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (ridx < (CB+1)'(count) && beats(h_rd, lch) && beats(h_rd, mov)) begin
            oth <= SB'(ridx); othv <= h_rd; state <= S_SWAP;
          end else if (beats(lch, mov)) begin
            oth <= SB'(lidx); othv <= lch; state <= S_SWAP;
          end else state <= S_RESP;
        end
        S_SWAP: begin
          swap_phase <= ~swap_phase;
          if (swap_phase) begin
            cur <= oth;
            state <= mode_up ? S_UPRD : S_DNL;
          end
        end
        S_RESP: begin
          rsp.status <= st;
          rsp.out_key <= okey;
          rsp.occupancy <= count;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(CAPACITY)) else $error("occupancy beyond capacity");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.command == ihq_pkg::CMD_POP && count == '0)
    |=> count == '0) else $error("pop of empty queue changed occupancy");
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");
`endif

endmodule

// ===== rtl/ihq_ram.sv =====
// ----------------------------------------------------------------------------
// ihq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ihq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
